FILE: hdl/rational_arithmetic_unit_core_macros.svh
// Assertion macros shared by the checker.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH

`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rau_pkg.sv
`default_nettype none
package rau_pkg;
    localparam int VW = 32;
    localparam int WW = 64;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_EQ  = 3'd4;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic          start;
        logic [WW-1:0] dividend;
        logic [WW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [WW-1:0] quot;
        logic [WW-1:0] rem;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_G0,  S_A_GW,  S_A_N0,  S_A_NW,  S_A_D0,  S_A_DW,
        S_B_G0,  S_B_GW,  S_B_N0,  S_B_NW,  S_B_D0,  S_B_DW,
        S_DISP,
        S_M1,    S_M2,    S_M3,    S_SUM,
        S_R_G0,  S_R_GW,  S_R_N0,  S_R_NW,  S_R_D0,  S_R_DW,
        S_CHK,   S_OUT
    } seq_state_t;
endpackage
`default_nettype wire

FILE: hdl/rau_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rau_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t      rsp
);
    import rau_pkg::*;

    div_state_t    state_reg, state_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [WW-1:0] q_reg, q_next;
    logic [WW-1:0] r_reg, r_next;
    logic [WW-1:0] d_reg, d_next;
    logic [WW:0]   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        d_next     = d_reg;
        trial      = {r_reg, q_reg[WW-1]} - {1'b0, d_reg};
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    q_next     = req.dividend;
                    r_next     = '0;
                    d_next     = req.divisor;
                    cnt_next   = 7'(WW);
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (!trial[WW])
                    r_next = trial[WW-1:0];
                else
                    r_next = {r_reg[WW-2:0], q_reg[WW-1]};
                q_next   = {q_reg[WW-2:0], ~trial[WW]};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    state_next = DIV_DONE;
            end
            DIV_DONE:
                state_next = DIV_IDLE;
            default:
                state_next = DIV_IDLE;
        endcase
    end

    assign rsp.done = (state_reg == DIV_DONE);
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;
endmodule
`default_nettype wire

FILE: hdl/rau_seq.sv
`default_nettype none
// Sequencer: runs all gcd and exact division work through one divider.
module rau_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [2:0]        cmd,
    input  wire logic [31:0]       a_num,
    input  wire logic [31:0]       a_den,
    input  wire logic [31:0]       b_num,
    input  wire logic [31:0]       b_den,
    output rau_pkg::div_req_t      dreq,
    input  wire rau_pkg::div_rsp_t drsp,
    output logic                   busy,
    output logic                   done,
    output logic [31:0]            res_num,
    output logic [30:0]            res_den,
    output logic                   is_equal,
    output logic [1:0]             status
);
    import rau_pkg::*;

    seq_state_t    state_reg, state_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic          an_reg, an_next, bn_reg, bn_next, rn_reg, rn_next;
    logic          and_reg, and_next, bnd_reg, bnd_next;
    logic [WW-1:0] am_reg, am_next, ad_reg, ad_next;
    logic [WW-1:0] bm_reg, bm_next, bd_reg, bd_next;
    logic [WW-1:0] rm_reg, rm_next, rd_reg, rd_next;
    logic [WW-1:0] x_reg, x_next, y_reg, y_next, g_reg, g_next;
    logic [WW-1:0] t1_reg, t1_next, t2_reg, t2_next;
    logic [1:0]    st_reg, st_next;
    logic          eq_reg, eq_next;
    logic [WW-1:0] mul_a, mul_b, mul_p;
    logic          s2;
    logic [WW-1:0] lim;

    // Magnitude of a VW-bit two's complement field, widened to WW bits.
    function automatic logic [WW-1:0] mag_of(input logic [31:0] v);
        logic [VW-1:0] x;
        logic [VW-1:0] n;
        x = v[VW-1:0];
        n = x[VW-1] ? (~x + 1'b1) : x;
        return WW'(n);
    endfunction

    // One shared 32x32 multiplier; operands never exceed 32 bits at its inputs.
    assign mul_p = 64'(mul_a[31:0]) * 64'(mul_b[31:0]);
    assign lim   = WW'(1) << (VW - 1);
    assign s2    = (cmd_reg == CMD_SUB) ? ~bn_reg : bn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        an_reg  <= an_next;
        bn_reg  <= bn_next;
        rn_reg  <= rn_next;
        and_reg <= and_next;
        bnd_reg <= bnd_next;
        am_reg  <= am_next;
        ad_reg  <= ad_next;
        bm_reg  <= bm_next;
        bd_reg  <= bd_next;
        rm_reg  <= rm_next;
        rd_reg  <= rd_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        g_reg   <= g_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        st_reg  <= st_next;
        eq_reg  <= eq_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        an_next = an_reg;  bn_next = bn_reg;  rn_next = rn_reg;
        and_next = and_reg; bnd_next = bnd_reg;
        am_next = am_reg;  ad_next = ad_reg;
        bm_next = bm_reg;  bd_next = bd_reg;
        rm_next = rm_reg;  rd_next = rd_reg;
        x_next = x_reg;    y_next = y_reg;    g_next = g_reg;
        t1_next = t1_reg;  t2_next = t2_reg;
        st_next = st_reg;  eq_next = eq_reg;
        dreq.start    = 1'b0;
        dreq.dividend = x_reg;
        dreq.divisor  = y_reg;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    an_next  = a_num[VW-1];
                    and_next = a_den[VW-1];
                    bn_next  = b_num[VW-1];
                    bnd_next = b_den[VW-1];
                    am_next  = mag_of(a_num);
                    ad_next  = mag_of(a_den);
                    bm_next  = mag_of(b_num);
                    bd_next  = mag_of(b_den);
                    x_next   = mag_of(a_num);
                    y_next   = mag_of(a_den);
                    st_next  = ST_OK;
                    eq_next  = 1'b0;
                    rn_next  = 1'b0;
                    rm_next  = '0;
                    rd_next  = WW'(1);
                    if (mag_of(a_den) == '0 || mag_of(b_den) == '0)
                    begin
                        st_next    = ST_ZERO;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_A_G0;
                end
            end
            // Euclid on (x, y), then exact divisions by the gcd.
            S_A_G0, S_B_G0, S_R_G0:
            begin
                if (y_reg == '0)
                begin
                    g_next = x_reg;
                    unique case (state_reg)
                        S_A_G0:
                        begin
                            x_next = am_reg; y_next = x_reg;
                            state_next = S_A_N0;
                        end
                        S_B_G0:
                        begin
                            x_next = bm_reg; y_next = x_reg;
                            state_next = S_B_N0;
                        end
                        default:
                        begin
                            x_next = rm_reg; y_next = x_reg;
                            state_next = S_R_N0;
                        end
                    endcase
                end
                else
                begin
                    dreq.start = 1'b1;
                    unique case (state_reg)
                        S_A_G0:  state_next = S_A_GW;
                        S_B_G0:  state_next = S_B_GW;
                        default: state_next = S_R_GW;
                    endcase
                end
            end
            S_A_GW, S_B_GW, S_R_GW:
            begin
                if (drsp.done)
                begin
                    x_next = y_reg;
                    y_next = drsp.rem;
                    unique case (state_reg)
                        S_A_GW:  state_next = S_A_G0;
                        S_B_GW:  state_next = S_B_G0;
                        default: state_next = S_R_G0;
                    endcase
                end
            end
            S_A_N0, S_A_D0, S_B_N0, S_B_D0, S_R_N0, S_R_D0:
            begin
                dreq.start = 1'b1;
                unique case (state_reg)
                    S_A_N0:  state_next = S_A_NW;
                    S_A_D0:  state_next = S_A_DW;
                    S_B_N0:  state_next = S_B_NW;
                    S_B_D0:  state_next = S_B_DW;
                    S_R_N0:  state_next = S_R_NW;
                    default: state_next = S_R_DW;
                endcase
            end
            S_A_NW:
                if (drsp.done)
                begin
                    am_next = drsp.quot;
                    x_next = ad_reg; y_next = g_reg;
                    state_next = S_A_D0;
                end
            S_A_DW:
                if (drsp.done)
                begin
                    ad_next = drsp.quot;
                    if (am_reg == '0)
                    begin
                        an_next = 1'b0; ad_next = WW'(1);
                    end
                    else
                        an_next = an_reg ^ and_reg;
                    x_next = bm_reg; y_next = bd_reg;
                    state_next = S_B_G0;
                end
            S_B_NW:
                if (drsp.done)
                begin
                    bm_next = drsp.quot;
                    x_next = bd_reg; y_next = g_reg;
                    state_next = S_B_D0;
                end
            S_B_DW:
                if (drsp.done)
                begin
                    bd_next = drsp.quot;
                    if (bm_reg == '0)
                    begin
                        bn_next = 1'b0; bd_next = WW'(1);
                    end
                    else
                        bn_next = bn_reg ^ bnd_reg;
                    state_next = S_DISP;
                end
            S_DISP:
            begin
                unique case (cmd_reg)
                    CMD_EQ:
                    begin
                        eq_next = (an_reg == bn_reg) && (am_reg == bm_reg)
                                  && (ad_reg == bd_reg);
                        state_next = S_OUT;
                    end
                    CMD_ADD, CMD_SUB:
                        state_next = S_M1;
                    CMD_MUL:
                    begin
                        rn_next = an_reg ^ bn_reg;
                        state_next = S_M1;
                    end
                    CMD_DIV:
                    begin
                        if (bm_reg == '0)
                        begin
                            st_next = ST_ZERO;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            rn_next = an_reg ^ bn_reg;
                            state_next = S_M1;
                        end
                    end
                    default:
                        state_next = S_OUT;
                endcase
            end
            S_M1:
            begin
                if (cmd_reg == CMD_DIV)
                begin
                    mul_a = am_reg; mul_b = bd_reg;
                end
                else if (cmd_reg == CMD_MUL)
                begin
                    mul_a = am_reg; mul_b = bm_reg;
                end
                else
                begin
                    // Sums are taken over a.den * b.den; the final reduction
                    // gives the same fraction as working over the lcm.
                    mul_a = ad_reg; mul_b = bd_reg;
                end
                t1_next = mul_p;
                state_next = S_M2;
            end
            S_M2:
            begin
                if (cmd_reg == CMD_DIV)
                begin
                    mul_a = ad_reg; mul_b = bm_reg;
                end
                else if (cmd_reg == CMD_MUL)
                begin
                    mul_a = ad_reg; mul_b = bd_reg;
                end
                else
                begin
                    mul_a = am_reg; mul_b = bd_reg;
                end
                if (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB)
                begin
                    rd_next = t1_reg;
                    t1_next = mul_p;
                    state_next = S_M3;
                end
                else
                begin
                    rm_next = t1_reg;
                    rd_next = mul_p;
                    state_next = S_SUM;
                end
            end
            S_M3:
            begin
                // Second term of the sum: b.mag * a.den.
                mul_a = bm_reg;
                mul_b = ad_reg;
                t2_next = mul_p;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB)
                begin
                    rm_next = '0;
                    if (an_reg == s2)
                    begin
                        rm_next = t1_reg + t2_reg;
                        rn_next = an_reg;
                    end
                    else if (t1_reg >= t2_reg)
                    begin
                        rm_next = t1_reg - t2_reg;
                        rn_next = an_reg;
                    end
                    else
                    begin
                        rm_next = t2_reg - t1_reg;
                        rn_next = s2;
                    end
                end
                if (rm_next == '0)
                begin
                    rn_next = 1'b0; rd_next = WW'(1);
                    state_next = S_CHK;
                end
                else
                begin
                    x_next = rm_next; y_next = rd_next;
                    state_next = S_R_G0;
                end
            end
            S_R_NW:
                if (drsp.done)
                begin
                    rm_next = drsp.quot;
                    x_next = rd_reg; y_next = g_reg;
                    state_next = S_R_D0;
                end
            S_R_DW:
                if (drsp.done)
                begin
                    rd_next = drsp.quot;
                    state_next = S_CHK;
                end
            S_CHK:
            begin
                if ((rn_reg ? (rm_reg > lim) : (rm_reg > lim - WW'(1)))
                    || rd_reg > lim - WW'(1))
                begin
                    st_next = ST_OVF;
                    rn_next = 1'b0; rm_next = '0; rd_next = WW'(1);
                end
                state_next = S_OUT;
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_OUT);
    assign res_num  = rn_reg ? (~rm_reg[31:0] + 32'd1) : rm_reg[31:0];
    assign res_den  = rd_reg[30:0];
    assign is_equal = eq_reg;
    assign status   = st_reg;
endmodule
`default_nettype wire

FILE: hdl/rational_arithmetic_unit_core.sv
`default_nettype none
// A zero operand denominator goes straight to the output state. Otherwise the run
// time is set by the number of Euclid steps, each a pass through the shared 64-bit
// restoring divider, which also does every exact division.
// Throughput: one item at a time; s_tready is low from acceptance until the
// result item is taken. Results wait in an output register.
// Reset: rst_n is asynchronous, active low, and empties the block.
module rational_arithmetic_unit_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
    input  wire logic [127:0] s_tdata,
    // cmd[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // res_num[31:0], res_den[62:32], is_equal[63], status[65:64], zero fill
    output logic [71:0]       m_tdata
);
    import rau_pkg::*;

    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        busy, done;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        is_equal;
    logic [1:0]  status;
    logic        ov_reg, ov_next;
    logic [71:0] od_reg;
    logic        accept;

    assign s_tready = !busy && !ov_reg;
    assign accept   = s_tvalid && s_tready;

    rau_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    rau_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .cmd      (s_tuser),
        .a_num    (s_tdata[31:0]),
        .a_den    (s_tdata[63:32]),
        .b_num    (s_tdata[95:64]),
        .b_den    (s_tdata[127:96]),
        .dreq     (dreq),
        .drsp     (drsp),
        .busy     (busy),
        .done     (done),
        .res_num  (res_num),
        .res_den  (res_den),
        .is_equal (is_equal),
        .status   (status)
    );

    always_comb
    begin
        ov_next = ov_reg;
        if (m_tvalid && m_tready)
            ov_next = 1'b0;
        if (done)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= ov_next;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            od_reg <= {6'd0, status, is_equal, res_den, res_num};
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
endmodule
`default_nettype wire

FILE: hdl/rau_checker.sv
`default_nettype none
`include "rational_arithmetic_unit_core_macros.svh"
module rau_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [71:0]  m_tdata
);
    `RAU_ASSERT_IMPL(a_one_at_a_time, clk, rst_n, m_tvalid, !s_tready, "input taken with result pending")
    `RAU_ASSERT_NEXT(a_busy_after_take, clk, rst_n, s_tvalid && s_tready, !s_tready, "ready right after accept")
    `RAU_ASSERT_IMPL(a_den_pos, clk, rst_n, m_tvalid, m_tdata[62:32] != 31'd0, "zero result denominator")
    `RAU_ASSERT_IMPL(a_status_code, clk, rst_n, m_tvalid, m_tdata[65:64] != 2'd3, "bad status code")
endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

FILE: sim/rational_arithmetic_unit_core_test.sv
`timescale 1ns / 1ps

module rational_arithmetic_unit_core_test;
    import rau_pkg::*;

    typedef struct {
        logic [31:0] num;
        logic [30:0] den;
        logic        eq;
        logic [1:0]  st;
    } rat_result_t;

    typedef struct {
        bit                neg;
        longint unsigned   mag;
        longint unsigned   den;
    } frac_t;

    class rational_scoreboard;
        rat_result_t expected_q[$];
        int          mismatches;

        function longint unsigned gcd64(longint unsigned x, longint unsigned y);
            longint unsigned t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        // Sign and magnitude of a 32-bit two's complement value; the most
        // negative value gives a magnitude of 2^31.
        function void split(logic [31:0] x, output bit neg, output longint unsigned mag);
            logic [31:0] m;
            neg = x[31];
            m = neg ? -x : x;
            mag = {32'd0, m};
        endfunction

        function frac_t reduce(bit nneg, longint unsigned nmag, bit dneg,
                               longint unsigned dmag);
            frac_t f;
            longint unsigned g;
            if (nmag == 0) begin
                f.neg = 0;
                f.mag = 0;
                f.den = 1;
            end
            else begin
                g = gcd64(nmag, dmag);
                f.neg = nneg != dneg;
                f.mag = nmag / g;
                f.den = dmag / g;
            end
            return f;
        endfunction

        function rat_result_t compute(logic [2:0] cmd, logic [31:0] an_raw,
                                      logic [31:0] ad_raw, logic [31:0] bn_raw,
                                      logic [31:0] bd_raw);
            rat_result_t res;
            frac_t a, b, r;
            bit an, ad, bn, bd, s2, sn;
            longint unsigned am, adm, bm, bdm, g, l, t1, t2, sm;
            longint unsigned lim;
            lim = 64'd1 << 31;
            res.num = 0;
            res.den = 1;
            res.eq = 0;
            res.st = ST_OK;
            split(an_raw, an, am);
            split(ad_raw, ad, adm);
            split(bn_raw, bn, bm);
            split(bd_raw, bd, bdm);
            if (adm == 0 || bdm == 0) begin
                res.st = ST_ZERO;
                return res;
            end
            a = reduce(an, am, ad, adm);
            b = reduce(bn, bm, bd, bdm);
            if (cmd == CMD_EQ) begin
                res.eq = a.neg == b.neg && a.mag == b.mag && a.den == b.den;
                return res;
            end
            if (cmd > CMD_EQ)
                return res;
            if (cmd == CMD_ADD || cmd == CMD_SUB) begin
                g = gcd64(a.den, b.den);
                l = (a.den / g) * b.den;
                t1 = a.mag * (l / a.den);
                t2 = b.mag * (l / b.den);
                s2 = (cmd == CMD_SUB) ? !b.neg : b.neg;
                if (a.neg == s2) begin
                    sm = t1 + t2;
                    sn = a.neg;
                end
                else if (t1 >= t2) begin
                    sm = t1 - t2;
                    sn = a.neg;
                end
                else begin
                    sm = t2 - t1;
                    sn = s2;
                end
                r = reduce(sn, sm, 0, l);
            end
            else if (cmd == CMD_MUL) begin
                r = reduce(a.neg != b.neg, a.mag * b.mag, 0, a.den * b.den);
            end
            else begin
                if (b.mag == 0) begin
                    res.st = ST_ZERO;
                    return res;
                end
                r = reduce(a.neg, a.mag * b.den, b.neg, a.den * b.mag);
            end
            if ((r.neg ? (r.mag > lim) : (r.mag > lim - 1)) || r.den > lim - 1) begin
                res.st = ST_OVF;
                return res;
            end
            res.num = r.neg ? -r.mag[31:0] : r.mag[31:0];
            res.den = r.den[30:0];
            return res;
        endfunction

        function void note_input(logic [2:0] cmd, logic [127:0] data);
            expected_q.push_back(compute(cmd, data[31:0], data[63:32],
                                         data[95:64], data[127:96]));
        endfunction

        function void check_result(logic [71:0] data);
            rat_result_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item %h", data);
                return;
            end
            e = expected_q.pop_front();
            if (data[31:0] !== e.num || data[62:32] !== e.den
                || data[63] !== e.eq || data[65:64] !== e.st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected num %0d den %0d eq %0d st %0d, got num %0d den %0d eq %0d st %0d",
                             $signed(e.num), e.den, e.eq, e.st, $signed(data[31:0]),
                             data[62:32], data[63], data[65:64]);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;

    rational_scoreboard sb;

    rational_arithmetic_unit_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // The receiver switches between always ready, random stalls and long stalls.
    int stall_mode;
    int stall_left;
    always @(negedge clk)
    begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 2000);
        end
        else
            stall_left--;
        case (stall_mode)
            0: m_tready = 1'b1;
            1: m_tready = 1'($urandom_range(0, 1));
            default: m_tready = ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic [2:0] cmd, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        s_tvalid = 1;
        s_tuser = cmd;
        s_tdata = {bd, bn, ad, an};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(cmd, s_tdata);
        @(negedge clk);
    endtask

    task automatic idle_cycles(int n);
        s_tvalid = 0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, 40) - 20;
            3, 4:    return $urandom_range(0, 131072) - 65536;
            5:       return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                                 : 32'h80000000 + $urandom_range(0, 3);
            6:       return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_den();
        logic [31:0] d;
        d = random_value();
        if ($urandom_range(0, 15) != 0 && d == 0)
            d = 1;
        return d;
    endfunction

    logic [2:0] rcmd;
    int         burst;

    initial begin
        sb = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        stall_mode = 0;
        stall_left = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_item(CMD_ADD, 1, 2, 1, 3);
        send_item(CMD_SUB, 1, 2, 3, -4);
        send_item(CMD_MUL, -6, 4, 10, -15);
        send_item(CMD_DIV, 3, 7, -9, 14);
        send_item(CMD_EQ, 2, 4, -3, -6);
        send_item(CMD_EQ, 2, 4, 1, 3);
        send_item(CMD_EQ, 0, -5, 0, 7);
        send_item(CMD_ADD, 1, 0, 1, 1);
        send_item(CMD_EQ, 1, 1, 1, 0);
        send_item(CMD_DIV, 5, 3, 0, 9);
        send_item(CMD_ADD, 32'h7fffffff, 1, 1, 1);
        send_item(CMD_SUB, 32'h80000000, 1, 1, 1);
        send_item(CMD_MUL, 32'h80000000, 1, -1, 1);
        send_item(CMD_DIV, 32'h80000000, 1, -1, 1);
        send_item(CMD_DIV, 1, 32'h80000000, 1, 1);
        send_item(CMD_MUL, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_item(CMD_ADD, 1, 32'h7fffffff, 1, 32'h7ffffffe);
        send_item(CMD_SUB, 32'h80000000, 32'h80000000, 1, 32'h80000000);
        send_item(CMD_MUL, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_item(3'd5, 3, 4, 5, 6);
        send_item(3'd6, 3, 0, 5, 6);
        send_item(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        wait_drained();

        burst = 0;
        for (int i = 0; i < 1350; i++) begin
            if (burst == 0) begin
                idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200));
                burst = $urandom_range(1, 30);
            end
            burst--;
            rcmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
            send_item(rcmd, random_value(), random_den(), random_value(), random_den());
        end
        wait_drained();
        repeat (2000) @(negedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #(64'd2_000_000_000);
        $display("FAILURE");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/rau_pkg.sv
hdl/rau_div.sv
hdl/rau_seq.sv
hdl/rational_arithmetic_unit_core.sv
hdl/rau_checker.sv
sim/rational_arithmetic_unit_core_test.sv
